### rtl/core/aarc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarc_pkg: shared types and constants
// Item structs, register indexes, mode and status codes, and the hex digit
// helper for the ASCII answer receiver.
// ----------------------------------------------------------------------------
package aarc_pkg;

  // Depth of the frame buffer; a frame never holds BUF_DEPTH characters.
  localparam int BUF_DEPTH = 256;
  localparam int CNT_W     = $clog2(BUF_DEPTH);

  localparam int TIMER_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TIMEOUT = 1'b1;

  // Input item modes.
  localparam logic [1:0] MODE_ARM  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSUM  = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Frame terminator characters.
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic               check_enable;
    logic [TIMER_W-1:0] answer_timeout;
  } cfg_t;

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

  function automatic logic is_terminator(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SEMI) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

### rtl/core/ascii_answer_receiver_checksum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_answer_receiver_checksum_top: ASCII answer receiver with checksum
// The result passes through the input register and then the output register,
// and out_valid rises once the result is held in the output register.
// Throughput: one input transfer per cycle, set by the state update in the
// frame unit; output back-pressure stalls the input register.
// Reset (rst_n, synchronous, active low) disarms the receiver, clears the
// frame and timer, and loads check_enable = 1 and answer_timeout = 100.
// ----------------------------------------------------------------------------
module ascii_answer_receiver_checksum_top import aarc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Configuration registers. Writes are always taken; software must write
  // them only while the receiver is idle, which the block does not enforce.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_enable   <= 1'b1;
      cfg_r.answer_timeout <= TIMER_W'(100);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHECK_ENABLE:   cfg_r.check_enable   <= cfg_data[0];
        REG_ANSWER_TIMEOUT: cfg_r.answer_timeout <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Output register state; its loading is described further down.
  logic      out_valid_r;
  out_item_t out_item_r;

  // Input register. The item held here is applied to the receiver state in
  // the cycle it moves on, which happens whenever the output register is
  // empty or its result is being transferred out.
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     advance;
  logic     proc;

  assign advance  = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // Frame collection, checksum check and timeout.
  logic      core_res_valid;
  out_item_t core_res;

  aarc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // Output register: loaded whenever it can advance, so items that make no
  // result simply leave it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res_valid) begin
      out_item_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

  // Only bytes and ticks produce results.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    core_res_valid |-> (proc && (s1_item_r.mode == MODE_BYTE ||
                                 s1_item_r.mode == MODE_TICK)))
    else $error("result from an item that cannot produce one");

  // A timeout result always reports a zero length.
  a_timeout_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_TIMEOUT) |->
      (out_item_r.frame_length == 8'd0))
    else $error("timeout result with nonzero length");
`endif

endmodule

### rtl/core/aarc_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarc_frame: frame collection and checking
// Holds the receiver state and applies one item per strobe, giving the
// result of that item, if any, in the same cycle.
// ----------------------------------------------------------------------------
module aarc_frame import aarc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      proc,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  logic               armed_r,   armed_nxt;
  logic [CNT_W-1:0]   count_r,   count_nxt;
  logic [7:0]         dsum_r,    dsum_nxt;
  logic [7:0]         prev_r,    prev_nxt;
  logic [7:0]         last_r,    last_nxt;
  logic [TIMER_W-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_W-1:0] tick_val;
  logic [1:0]         term_status;

  always_comb begin
    tick_val = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + TIMER_W'(1);
    term_status = ST_OK;
    if (cfg.check_enable) begin
      if (count_r < CNT_W'(3)) begin
        term_status = ST_SHORT;
      end else if (prev_r != hex_digit(dsum_r[7:4]) ||
                   last_r != hex_digit(dsum_r[3:0])) begin
        term_status = ST_BADSUM;
      end
    end
  end

  always_comb begin
    armed_nxt   = armed_r;
    count_nxt   = count_r;
    dsum_nxt    = dsum_r;
    prev_nxt    = prev_r;
    last_nxt    = last_r;
    elapsed_nxt = elapsed_r;
    res_valid   = 1'b0;
    res.status       = ST_OK;
    res.frame_length = 8'(count_r);
    if (proc) begin
      case (item.mode)
        MODE_ARM: begin
          armed_nxt   = 1'b1;
          count_nxt   = '0;
          dsum_nxt    = '0;
          prev_nxt    = '0;
          last_nxt    = '0;
          elapsed_nxt = '0;
        end
        MODE_BYTE: begin
          if (armed_r) begin
            if (is_terminator(item.data_byte)) begin
              res_valid  = 1'b1;
              res.status = term_status;
              armed_nxt  = 1'b0;
            end else begin
              elapsed_nxt = '0;
              if (count_r == CNT_W'(BUF_DEPTH - 1)) begin
                // Overflow: drop the frame and the byte, start over.
                count_nxt = '0;
                dsum_nxt  = '0;
                prev_nxt  = '0;
                last_nxt  = '0;
              end else begin
                if (count_r >= CNT_W'(2)) begin
                  dsum_nxt = dsum_r + prev_r;
                end
                prev_nxt  = last_r;
                last_nxt  = item.data_byte;
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
        end
        MODE_TICK: begin
          if (armed_r) begin
            elapsed_nxt = tick_val;
            if (tick_val >= cfg.answer_timeout) begin
              res_valid        = 1'b1;
              res.status       = ST_TIMEOUT;
              res.frame_length = '0;
              armed_nxt        = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      count_r   <= '0;
      dsum_r    <= '0;
      prev_r    <= '0;
      last_r    <= '0;
      elapsed_r <= '0;
    end else begin
      armed_r   <= armed_nxt;
      count_r   <= count_nxt;
      dsum_r    <= dsum_nxt;
      prev_r    <= prev_nxt;
      last_r    <= last_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule
